>>> rtl/encoder_angle_turn_speed_tracker_assert.svh
// assertion macros used by the tracker port checker
`ifndef ENCODER_ANGLE_TURN_SPEED_TRACKER_ASSERT_SVH
`define ENCODER_ANGLE_TURN_SPEED_TRACKER_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define EATST_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tracker check failed");

// next-cycle implication, checked on every rising clock edge outside reset
`define EATST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tracker check failed");

`endif

>>> rtl/eatst_pkg.sv
// shared widths, constants and register indexes of the angle tracker
package eatst_pkg;

   // field widths
   localparam int RAW_W   = 16;
   localparam int MECH_W  = 14;
   localparam int ELEC_W  = 16;
   localparam int TURN_W  = 32;
   localparam int SPEED_W = 32;
   localparam int SCALE_W = 16;

   // one mechanical turn and one electrical period in raw counts
   localparam int MECH_COUNTS = 1 << MECH_W;
   localparam int ELEC_PERIOD = 2340;

   // turn jump threshold as a fraction of a turn
   localparam int JUMP_NUM = 4;
   localparam int JUMP_DEN = 5;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_MECH_ZERO   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEC_ZERO   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_SCALE = 2'd2;

   localparam logic [MECH_W-1:0]  MECH_ZERO_RST   = '0;
   localparam logic [ELEC_W-1:0]  ELEC_ZERO_RST   = 16'd48117;
   localparam logic [SCALE_W-1:0] SPEED_SCALE_RST = 16'd1;

   // pipeline depth from input register to result register
   localparam int PIPE_DEPTH = 5;

endpackage

>>> rtl/encoder_angle_turn_speed_tracker.sv
// encoder angle, turn count and speed tracker, five-stage pipeline
// path from the accepted word to rsp_valid: input register, three working stages,
// result register; throughput: one word per cycle while the result side does not stall
// the depth is set by the electrical path (two reciprocal multiplies, each
// followed by a correction) and the registered speed multiply and saturation
// reset: synchronous, clears all valid flags, turn state and last angle, and
// loads the configuration registers with their reset values
module encoder_angle_turn_speed_tracker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_op,
   input  logic [eatst_pkg::RAW_W-1:0]            req_raw_angle,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [eatst_pkg::MECH_W-1:0]           rsp_mech_angle,
   output logic [eatst_pkg::ELEC_W-1:0]           rsp_elec_angle,
   output logic signed [eatst_pkg::TURN_W-1:0]    rsp_turns,
   output logic signed [eatst_pkg::SPEED_W-1:0]   rsp_speed,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [eatst_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [eatst_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int RAW_W   = eatst_pkg::RAW_W;
   localparam int MECH_W  = eatst_pkg::MECH_W;
   localparam int ELEC_W  = eatst_pkg::ELEC_W;
   localparam int TURN_W  = eatst_pkg::TURN_W;
   localparam int SPEED_W = eatst_pkg::SPEED_W;
   localparam int SCALE_W = eatst_pkg::SCALE_W;

   localparam int JUMP_W  = MECH_W + 4;
   localparam int SPAN_W  = TURN_W + MECH_W + 1;
   localparam int CLAMP_W = TURN_W + 1;
   localparam int PROD_W  = CLAMP_W + SCALE_W + 1;
   localparam int QW      = 2 * RAW_W;
   localparam int EW2     = 2 * ELEC_W;
   localparam int PW2     = 3 * ELEC_W;

   localparam int unsigned ELEC_RECIP1 = (1 << RAW_W) / eatst_pkg::ELEC_PERIOD;
   localparam longint unsigned ELEC_RECIP2 =
      (64'd1 << EW2) / eatst_pkg::ELEC_PERIOD;
   localparam int JUMP_LIMIT = eatst_pkg::JUMP_NUM * eatst_pkg::MECH_COUNTS;

   // configuration and tracking state
   logic [MECH_W-1:0]  mech_zero_ff;
   logic [ELEC_W-1:0]  elec_zero_ff;
   logic [SCALE_W-1:0] speed_scale_ff;
   logic [MECH_W-1:0]  last_angle_ff;
   logic [TURN_W-1:0]  turn_count_ff;
   logic [TURN_W-1:0]  last_turn_ff;

   // stage registers
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic s1_op_ff, s2_op_ff, s3_op_ff, s4_op_ff, s5_op_ff;
   logic [RAW_W-1:0] s1_raw_ff, s2_raw_ff;
   logic [RAW_W-1:0] s2_quot_ff;
   logic [MECH_W-1:0] s2_mech_ff, s3_mech_ff, s4_mech_ff, s5_mech_ff;
   logic [TURN_W-1:0] s2_turns_ff, s3_turns_ff, s4_turns_ff, s5_turns_ff;
   logic signed [CLAMP_W-1:0] s2_span_ff;
   logic signed [PROD_W-1:0] s3_prod_ff;
   logic [RAW_W-1:0] s3_res_ff, s4_res_ff;
   logic [ELEC_W-1:0] s4_quot_ff;
   logic [SPEED_W-1:0] s4_speed_ff, s5_speed_ff;
   logic [ELEC_W-1:0] s5_elec_ff;

   logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;
   logic track_load;

   // ready chain: a stage takes a word when empty or when it drains
   assign s5_ready = !s5_valid_ff || rsp_ready;
   assign s4_ready = !s4_valid_ff || s5_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;
   assign csr_ready = 1'b1;
   assign track_load = s1_valid_ff && s2_ready;

   logic s1_valid_in, s2_valid_in, s3_valid_in, s4_valid_in, s5_valid_in;
   assign s1_valid_in = s1_ready ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;
   assign s4_valid_in = s4_ready ? s3_valid_ff : s4_valid_ff;
   assign s5_valid_in = s5_ready ? s4_valid_ff : s5_valid_ff;

   // stage 1 -> 2: mechanical angle, turn tracking, speed span, coarse quotient
   logic [MECH_W-1:0] mech_in;
   logic signed [MECH_W:0] angle_diff;
   logic [MECH_W:0] angle_mag;
   logic jump;
   logic [TURN_W-1:0] turn_next;
   logic [TURN_W-1:0] turn_delta;
   logic [SPAN_W-1:0] span;
   logic span_fits;
   logic signed [CLAMP_W-1:0] span_in;
   logic [QW-1:0] quot1_prod;
   logic [RAW_W-1:0] quot1_in;
   logic [MECH_W-1:0] last_angle_in;
   logic [TURN_W-1:0] turn_count_in;
   logic [TURN_W-1:0] last_turn_in;

   always_comb begin
      mech_in = s1_raw_ff[MECH_W-1:0] - mech_zero_ff;
      angle_diff = $signed({1'b0, mech_in}) - $signed({1'b0, last_angle_ff});
      angle_mag = angle_diff[MECH_W] ? (MECH_W + 1)'(-angle_diff)
                                     : (MECH_W + 1)'(angle_diff);
      jump = (JUMP_W'(angle_mag) * JUMP_W'(eatst_pkg::JUMP_DEN)) > JUMP_W'(JUMP_LIMIT);
      // a forward jump means the shaft wrapped backward
      if (!jump) begin
         turn_next = turn_count_ff;
      end else if (angle_diff[MECH_W]) begin
         turn_next = turn_count_ff + TURN_W'(1);
      end else begin
         turn_next = turn_count_ff - TURN_W'(1);
      end
      turn_delta = turn_next - last_turn_ff;
      span = {turn_delta[TURN_W-1], turn_delta, {MECH_W{1'b0}}}
           + {{TURN_W{angle_diff[MECH_W]}}, angle_diff};
      // outside 33 bits the product saturates for any nonzero scale
      span_fits = (&span[SPAN_W-1:CLAMP_W-1]) || !(|span[SPAN_W-1:CLAMP_W-1]);
      if (span_fits) begin
         span_in = $signed(span[CLAMP_W-1:0]);
      end else if (span[SPAN_W-1]) begin
         span_in = $signed({1'b1, {(CLAMP_W - 1){1'b0}}});
      end else begin
         span_in = $signed({1'b0, {(CLAMP_W - 1){1'b1}}});
      end
      quot1_prod = QW'(s1_raw_ff) * QW'(ELEC_RECIP1);
      quot1_in = quot1_prod[QW-1:RAW_W];

      if (s1_op_ff) begin
         last_angle_in = last_angle_ff;
         turn_count_in = '0;
         last_turn_in = last_turn_ff;
      end else begin
         last_angle_in = mech_in;
         turn_count_in = turn_next;
         last_turn_in = turn_next;
      end
   end

   // stage 2 -> 3: speed product, residue of the electrical period
   logic signed [PROD_W-1:0] prod_in;
   logic [QW-1:0] rem1;
   logic [QW-1:0] rem1_fix;
   logic [RAW_W-1:0] res_in;

   always_comb begin
      prod_in = s2_span_ff * $signed({1'b0, speed_scale_ff});
      rem1 = QW'(s2_raw_ff) - QW'(s2_quot_ff) * QW'(eatst_pkg::ELEC_PERIOD);
      rem1_fix = (rem1 >= QW'(eatst_pkg::ELEC_PERIOD))
               ? rem1 - QW'(eatst_pkg::ELEC_PERIOD) : rem1;
      res_in = rem1_fix[RAW_W-1:0];
   end

   // stage 3 -> 4: speed saturation, coarse electrical scale
   logic [SPEED_W-1:0] speed_in;
   logic [PW2-1:0] quot2_prod;
   logic [ELEC_W-1:0] quot2_in;
   logic prod_fits;

   always_comb begin
      prod_fits = (&s3_prod_ff[PROD_W-1:SPEED_W-1]) || !(|s3_prod_ff[PROD_W-1:SPEED_W-1]);
      if (s3_op_ff) begin
         speed_in = '0;
      end else if (prod_fits) begin
         speed_in = s3_prod_ff[SPEED_W-1:0];
      end else if (s3_prod_ff[PROD_W-1]) begin
         speed_in = {1'b1, {(SPEED_W - 1){1'b0}}};
      end else begin
         speed_in = {1'b0, {(SPEED_W - 1){1'b1}}};
      end
      quot2_prod = PW2'(s3_res_ff) * PW2'(ELEC_RECIP2);
      quot2_in = quot2_prod[EW2-1:ELEC_W];
   end

   // stage 4 -> 5: quotient correction, electrical zero
   logic [EW2-1:0] rem2;
   logic [ELEC_W-1:0] elec_scaled;
   logic [ELEC_W-1:0] elec_in;

   always_comb begin
      rem2 = {EW2'(s4_res_ff)} << ELEC_W;
      rem2 = rem2 - EW2'(s4_quot_ff) * EW2'(eatst_pkg::ELEC_PERIOD);
      elec_scaled = (rem2 >= EW2'(eatst_pkg::ELEC_PERIOD))
                  ? s4_quot_ff + ELEC_W'(1) : s4_quot_ff;
      elec_in = s4_op_ff ? '0 : elec_scaled - elec_zero_ff;
   end

   // control, state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         last_angle_ff <= '0;
         turn_count_ff <= '0;
         last_turn_ff <= '0;
         mech_zero_ff <= eatst_pkg::MECH_ZERO_RST;
         elec_zero_ff <= eatst_pkg::ELEC_ZERO_RST;
         speed_scale_ff <= eatst_pkg::SPEED_SCALE_RST;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
         s5_valid_ff <= s5_valid_in;
         if (track_load) begin
            last_angle_ff <= last_angle_in;
            turn_count_ff <= turn_count_in;
            last_turn_ff <= last_turn_in;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               eatst_pkg::CSR_MECH_ZERO:   mech_zero_ff <= csr_data[MECH_W-1:0];
               eatst_pkg::CSR_ELEC_ZERO:   elec_zero_ff <= csr_data[ELEC_W-1:0];
               eatst_pkg::CSR_SPEED_SCALE: speed_scale_ff <= csr_data[SCALE_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_op_ff <= req_op;
         s1_raw_ff <= req_raw_angle;
      end
      if (s2_ready) begin
         s2_op_ff <= s1_op_ff;
         s2_raw_ff <= s1_raw_ff;
         s2_quot_ff <= quot1_in;
         s2_mech_ff <= s1_op_ff ? '0 : mech_in;
         s2_turns_ff <= turn_count_in;
         s2_span_ff <= span_in;
      end
      if (s3_ready) begin
         s3_op_ff <= s2_op_ff;
         s3_mech_ff <= s2_mech_ff;
         s3_turns_ff <= s2_turns_ff;
         s3_prod_ff <= prod_in;
         s3_res_ff <= res_in;
      end
      if (s4_ready) begin
         s4_op_ff <= s3_op_ff;
         s4_mech_ff <= s3_mech_ff;
         s4_turns_ff <= s3_turns_ff;
         s4_speed_ff <= speed_in;
         s4_res_ff <= s3_res_ff;
         s4_quot_ff <= quot2_in;
      end
      if (s5_ready) begin
         s5_op_ff <= s4_op_ff;
         s5_mech_ff <= s4_mech_ff;
         s5_turns_ff <= s4_turns_ff;
         s5_speed_ff <= s4_speed_ff;
         s5_elec_ff <= elec_in;
      end
   end

   assign rsp_valid = s5_valid_ff;
   assign rsp_mech_angle = s5_op_ff ? '0 : s5_mech_ff;
   assign rsp_elec_angle = s5_elec_ff;
   assign rsp_turns = $signed(s5_turns_ff);
   assign rsp_speed = $signed(s5_speed_ff);

endmodule

>>> rtl/eatst_checker.sv
// port-level checks for the angle tracker, bound to the top level
`include "encoder_angle_turn_speed_tracker_assert.svh"

module eatst_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // a pending result word is not withdrawn
   `EATST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // reset empties the pipeline
   `EATST_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // an open result side never blocks the input
   `EATST_ASSERT_NOW(a_no_stall, clock, reset, rsp_ready, req_ready)

   // with no back pressure a word comes out after the fixed pipeline depth
   `EATST_ASSERT_NEXT(a_latency, clock, reset, req_valid && req_ready ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready, rsp_valid)

endmodule

bind encoder_angle_turn_speed_tracker eatst_checker u_eatst_checker (.*);

>>> sim/tb_encoder_angle_turn_speed_tracker.sv
// self-checking testbench for the encoder angle, turn count and speed tracker
module tb_encoder_angle_turn_speed_tracker;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RAW_W      = eatst_pkg::RAW_W;
   localparam int MECH_W     = eatst_pkg::MECH_W;
   localparam int ELEC_W     = eatst_pkg::ELEC_W;
   localparam int TURN_W     = eatst_pkg::TURN_W;
   localparam int SPEED_W    = eatst_pkg::SPEED_W;
   localparam int SCALE_W    = eatst_pkg::SCALE_W;
   localparam int CSR_IDX_W  = eatst_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = eatst_pkg::CSR_DATA_W;

   localparam int HALF_PERIOD = 4;
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   // marks a clear word in the directed sequences
   localparam int CLEAR_MARK   = -1;
   localparam int STALL_MAX    = 8;
   localparam int LONG_HOLD    = 150;
   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_WORDS  = 140;
   localparam longint SPEED_MAX = 64'sd2147483647;
   localparam longint SPEED_MIN = -64'sd2147483648;

   typedef struct {
      logic             op;
      logic [RAW_W-1:0] raw;
   } enc_word_type;

   typedef struct {
      logic [MECH_W-1:0]         mech;
      logic [ELEC_W-1:0]         elec;
      logic signed [TURN_W-1:0]  turns;
      logic signed [SPEED_W-1:0] speed;
   } track_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_op = OP_SAMPLE;
   logic [RAW_W-1:0]          req_raw_angle = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [MECH_W-1:0]         rsp_mech_angle;
   logic [ELEC_W-1:0]         rsp_elec_angle;
   logic signed [TURN_W-1:0]  rsp_turns;
   logic signed [SPEED_W-1:0] rsp_speed;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_data = '0;

   // register copies and tracker state as the block should hold them
   logic [MECH_W-1:0]  cfg_mech_zero   = eatst_pkg::MECH_ZERO_RST;
   logic [ELEC_W-1:0]  cfg_elec_zero   = eatst_pkg::ELEC_ZERO_RST;
   logic [SCALE_W-1:0] cfg_speed_scale = eatst_pkg::SPEED_SCALE_RST;
   logic [MECH_W-1:0]  trk_last_angle  = '0;
   logic [TURN_W-1:0]  trk_turns       = '0;
   logic [TURN_W-1:0]  trk_last_turns  = '0;

   enc_word_type     pending_words[$];
   track_result_type expected_results[$];
   track_result_type rsp_expect;
   bit            idle_on = 1'b1;
   int            gap_left = 0;
   int            stall_left = 0;
   int            stall_draw = 0;
   int            hold_left = 0;
   int            results_seen = 0;
   int            bad_results = 0;
   int            idle_cycles = 0;

   encoder_angle_turn_speed_tracker i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_raw_angle  (req_raw_angle),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_mech_angle (rsp_mech_angle),
      .rsp_elec_angle (rsp_elec_angle),
      .rsp_turns      (rsp_turns),
      .rsp_speed      (rsp_speed),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic track_result_type advance_tracker(input enc_word_type w);
      track_result_type  r;
      logic [MECH_W-1:0] mech;
      logic [TURN_W-1:0] turn_diff;
      longint            elec_full;
      longint            delta;
      longint            mag;
      longint            turn_delta;
      longint            spd;
      r = '{default: '0};
      if (w.op == OP_CLEAR) begin
         // last angle and last turn count survive, so the next sample sees the step
         trk_turns = '0;
         return r;
      end
      mech = w.raw[MECH_W-1:0] - cfg_mech_zero;
      elec_full = (longint'(w.raw) % eatst_pkg::ELEC_PERIOD) * 65536
                / eatst_pkg::ELEC_PERIOD;
      r.elec = elec_full[ELEC_W-1:0] - cfg_elec_zero;
      delta = longint'(mech) - longint'(trk_last_angle);
      mag = (delta < 0) ? -delta : delta;
      if (eatst_pkg::JUMP_DEN * mag > eatst_pkg::JUMP_NUM * eatst_pkg::MECH_COUNTS) begin
         // forward jump across the wrap means the shaft went backward
         trk_turns = (delta > 0) ? trk_turns - 1 : trk_turns + 1;
      end
      turn_diff = trk_turns - trk_last_turns;
      turn_delta = longint'(signed'(turn_diff));
      spd = (turn_delta * eatst_pkg::MECH_COUNTS + delta) * longint'(cfg_speed_scale);
      if (spd > SPEED_MAX) spd = SPEED_MAX;
      if (spd < SPEED_MIN) spd = SPEED_MIN;
      r.mech = mech;
      r.turns = trk_turns;
      r.speed = spd[SPEED_W-1:0];
      trk_last_angle = mech;
      trk_last_turns = trk_turns;
      return r;
   endfunction

   task automatic push_word(input logic op, input logic [RAW_W-1:0] raw);
      enc_word_type w;
      w.op = op;
      w.raw = raw;
      pending_words.push_back(w);
   endtask

   task automatic push_list(input int vals[$]);
      foreach (vals[k]) begin
         if (vals[k] == CLEAR_MARK) push_word(OP_CLEAR, RAW_W'($urandom));
         else push_word(OP_SAMPLE, RAW_W'(vals[k]));
      end
   endtask

   // shaft turning in segments of steady step, with clears and noise mixed in
   task automatic add_spin(input int count);
      int pos;
      int step;
      int seg_left;
      int pick;
      pos = $urandom_range(0, eatst_pkg::MECH_COUNTS - 1);
      step = 0;
      seg_left = 0;
      repeat (count) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(4, 40);
            if ($urandom_range(0, 9) < 7) step = $urandom_range(0, 3300);
            else step = $urandom_range(0, eatst_pkg::MECH_COUNTS - 1);
            if ($urandom_range(0, 1) == 1) step = -step;
         end
         seg_left--;
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            push_word(OP_CLEAR, RAW_W'($urandom));
         end else if (pick < 10) begin
            push_word(OP_SAMPLE, RAW_W'($urandom));
         end else begin
            pos = (pos + step) & (eatst_pkg::MECH_COUNTS - 1);
            push_word(OP_SAMPLE, {2'($urandom), pos[MECH_W-1:0]});
         end
      end
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         eatst_pkg::CSR_MECH_ZERO:   cfg_mech_zero = val[MECH_W-1:0];
         eatst_pkg::CSR_ELEC_ZERO:   cfg_elec_zero = val[ELEC_W-1:0];
         eatst_pkg::CSR_SPEED_SCALE: cfg_speed_scale = val[SCALE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_results.size() != 0);
   endtask

   task automatic flag_bad(input string msg);
      bad_results++;
      if (bad_results <= 10) $display("%s", msg);
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_results.push_back(
               advance_tracker(enc_word_type'{req_op, req_raw_angle}));
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               req_valid <= 1'b0;
               gap_left <= gap_left - 1;
            end else if (pending_words.size() != 0) begin
               req_valid <= 1'b1;
               req_op <= pending_words[0].op;
               req_raw_angle <= pending_words[0].raw;
               void'(pending_words.pop_front());
               gap_left <= idle_on ? $urandom_range(0, STALL_MAX) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
               flag_bad($sformatf("unexpected word: mech %0d elec %0d turns %0d speed %0d",
                  rsp_mech_angle, rsp_elec_angle, rsp_turns, rsp_speed));
            end else begin
               rsp_expect = expected_results.pop_front();
               if (rsp_mech_angle !== rsp_expect.mech || rsp_elec_angle !== rsp_expect.elec
                     || rsp_turns !== rsp_expect.turns || rsp_speed !== rsp_expect.speed)
                  flag_bad($sformatf({"mismatch at word %0d: exp mech %0d elec %0d turns %0d",
                     " speed %0d, got mech %0d elec %0d turns %0d speed %0d"}, results_seen,
                     rsp_expect.mech, rsp_expect.elec, rsp_expect.turns, rsp_expect.speed,
                     rsp_mech_angle, rsp_elec_angle, rsp_turns, rsp_speed));
            end
         end
         // two long hold-offs so the pipeline backs up into the input
         if (rsp_valid && rsp_ready && (results_seen == 250 || results_seen == 700)) begin
            rsp_ready <= 1'b0;
            hold_left <= LONG_HOLD;
         end else if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (rsp_valid && rsp_ready) begin
            stall_draw = idle_on ? $urandom_range(0, STALL_MAX) : 0;
            rsp_ready <= (stall_draw == 0);
            stall_left <= (stall_draw > 0) ? stall_draw - 1 : 0;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
            || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int basic_seq[$];
      int sat_seq[$];
      logic [CSR_DATA_W-1:0] mz;
      logic [CSR_DATA_W-1:0] ez;
      logic [CSR_DATA_W-1:0] sc;
      // threshold on both sides, full-turn jumps, clears, electrical period edges
      basic_seq = '{0, 13107, 0, 13108, 0, 16383, 65535, 0, CLEAR_MARK, 16383,
                    CLEAR_MARK, 16383, 2339, 2340};
      // forward spin then clear drives speed to the low rail, backward spin to the high one
      sat_seq = '{0, 8000, 16000, 0, 8000, 16000, 0, CLEAR_MARK, 16383,
                  8000, 0, 16000, CLEAR_MARK, 0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      push_list(basic_seq);
      wait_drained();

      csr_write(eatst_pkg::CSR_SPEED_SCALE, 16'hFFFF);
      csr_write(CSR_UNUSED, 16'h5A5A);
      push_list(sat_seq);
      wait_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin mz = 16'hFFFF; ez = 16'h0000; sc = 16'h0000; end
            1: begin mz = 16'h0000; ez = 16'hFFFF; sc = 16'h0001; end
            2: begin mz = 16'hC000; ez = 16'($urandom); sc = 16'hFFFF; end
            default: begin
               mz = 16'($urandom);
               ez = 16'($urandom);
               sc = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 40)) : 16'($urandom);
            end
         endcase
         csr_write(eatst_pkg::CSR_MECH_ZERO, mz);
         csr_write(eatst_pkg::CSR_ELEC_ZERO, ez);
         csr_write(eatst_pkg::CSR_SPEED_SCALE, sc);
         if (phase % 3 == 2) csr_write(CSR_UNUSED, 16'($urandom));
         idle_on = (phase % 3 != 1);
         add_spin(PHASE_WORDS);
         wait_drained();
      end

      repeat (eatst_pkg::PIPE_DEPTH + 4) @(posedge clock);
      if (bad_results == 0 && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
